[rtl/rtdf_pkg.sv]
// Package for the recent-tag duplicate filter.
// Holds the ring geometry, the tag mask, the operation codes and the shared types.
// It depends on nothing else.
package rtdf_pkg;

	localparam int TAG_BYTES  = 4;
	localparam int RING_DEPTH = 16;
	localparam int TAG_W      = 32;
	localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

	// Only the low TAG_BYTES bytes of a tag take part; bytes past the field are zero.
	localparam logic [TAG_W-1:0] TAG_MASK = (TAG_BYTES >= 4) ? {TAG_W{1'b1}} :
		TAG_W'((64'd1 << (8 * TAG_BYTES)) - 64'd1);

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_LAST,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic clear;
		logic compare;
	} match_ctl_t;

endpackage

[rtl/rtdf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for the tag ring; it depends on nothing else.
module rtdf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/rtdf_match.sv]
// Shared byte-wise tag comparator with a sticky hit register.
// Depends on rtdf_pkg for the tag width, byte count and control struct.
module rtdf_match import rtdf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  match_ctl_t       ctl,
	input  logic [TAG_W-1:0] key,
	input  logic [TAG_W-1:0] entry,
	input  logic             entry_valid,
	output logic             hit
);

	logic [TAG_W-1:0] entry_eff;
	logic             all_eq;
	logic             hit_q;

	// An entry that was never written reads as the all-zero reset value.
	assign entry_eff = entry_valid ? (entry & TAG_MASK) : '0;

	always_comb begin
		all_eq = 1'b1;
		for (int b = 0; b < TAG_W / 8; b++) begin
			if (entry_eff[8*b +: 8] != key[8*b +: 8]) begin
				all_eq = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.clear) begin
			hit_q <= 1'b0;
		end else if (ctl.compare && all_eq) begin
			hit_q <= 1'b1;
		end
	end

	assign hit = hit_q;

endmodule

[rtl/recent_tag_duplicate_filter_core.sv]
// Top level of the recent-tag duplicate filter: sequencer, write pointer, valid bits.
// Depends on rtdf_pkg, rtdf_ram and rtdf_match.
//
// How the block is used:
// A beat is offered by raising start with operation and tag; it is taken at a
// rising clock edge where start is high and busy is low.
// A record beat (operation = 0) writes the masked tag at the write pointer in the
// cycle it is taken, advances the pointer with wrap, and gives no result; busy
// stays low, so the next beat may come in the following cycle.
// A query beat (operation = 1) raises busy. The sequencer walks the ring, one
// entry per cycle through the single RAM read port, and the shared comparator
// checks every byte of each entry against the query tag. The walk reads every
// entry in ST_SCAN, compares the last registered read in ST_LAST and reports in
// ST_REPORT; done is high for exactly one cycle with seen, in the last cycle
// that busy is high. The receiver cannot stall: done is high for one cycle
// only, and seen holds only until the next beat of either kind is taken.
// Reset clears the write pointer, the sequencer and the per-entry valid bits at
// once; an entry that is not valid reads as zero, so an all-zero tag hits until
// every entry has been overwritten. No clearing pass is needed.
module recent_tag_duplicate_filter_core import rtdf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             operation,
	input  logic [TAG_W-1:0] tag,
	output logic             done,
	output logic             seen
);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  wp_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [RING_DEPTH-1:0] valid_q;
	logic [TAG_W-1:0]  key_q;
	logic              vld_s1;
	logic [TAG_W-1:0]  rdata;
	logic              accept;
	logic              rec_we;
	logic              cnt_last;
	match_ctl_t        mctl;
	logic              hit;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	assign accept   = start && !busy;
	assign rec_we   = accept && (operation == OP_RECORD);
	assign cnt_last = (cnt_q == LAST_IDX);

	// Next-state logic of the query sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (operation == OP_QUERY)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (cnt_last) begin
					state_d = ST_LAST;
				end
			end
			ST_LAST:   state_d = ST_REPORT;
			ST_REPORT: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Output logic of the sequencer.
	always_comb begin
		busy         = 1'b1;
		done         = 1'b0;
		mctl.clear   = 1'b0;
		mctl.compare = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				mctl.clear = accept;
			end
			ST_SCAN: begin
				// Data from the previous read is compared; the first cycle has none yet.
				mctl.compare = (cnt_q != '0);
			end
			ST_LAST:   mctl.compare = 1'b1;
			ST_REPORT: done = 1'b1;
			default:   busy = 1'b1;
		endcase
	end

	assign seen = hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			wp_q    <= '0;
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_last ? '0 : cnt_q + IDX_W'(1);
			end else begin
				cnt_q <= '0;
			end
			vld_s1 <= valid_q[cnt_q];
			if (rec_we) begin
				valid_q[wp_q] <= 1'b1;
				wp_q <= (wp_q == LAST_IDX) ? '0 : wp_q + IDX_W'(1);
			end
		end
	end

	// The query key is payload only.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= tag & TAG_MASK;
		end
	end

	rtdf_ram #(
		.WIDTH(TAG_W),
		.DEPTH(RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (rec_we),
		.waddr(wp_q),
		.wdata(tag & TAG_MASK),
		.raddr(cnt_q),
		.rdata(rdata)
	);

	rtdf_match u_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (mctl),
		.key        (key_q),
		.entry      (rdata),
		.entry_valid(vld_s1),
		.hit        (hit)
	);

	// A query beat always makes the block busy in the next cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (operation == OP_QUERY)) |=> busy)
		else $error("query beat did not start the ring walk");

	// A record beat never blocks the next beat.
	a_record_free: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (operation == OP_RECORD)) |=> !busy)
		else $error("record beat left the block busy");

	// The result comes in the last busy cycle, and the block is free right after.
	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy ##1 !busy)
		else $error("result strobe not at the end of a query");

	// A result is preceded by the final compare cycle.
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_LAST))
		else $error("result strobe without a completed walk");

	// The write pointer never leaves the ring.
	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q <= LAST_IDX)
		else $error("write pointer out of range");

endmodule
